>>> rtl/rsrgb_pkg.sv
// ----------------------------------------------------------------------------
// rsrgb_pkg
// Shared constants for the Reinhard tonemap / sRGB encode pipeline.
// ----------------------------------------------------------------------------
package rsrgb_pkg;

    // fraction bits of the linear input channels
    localparam int FRAC_BITS = 16;

    // luminance and divisor width: covers 2^(FRAC_BITS+16) + max luminance
    localparam int DEN_W = 49;
    localparam logic [DEN_W-1:0] DEN_ONE = DEN_W'(1) << (FRAC_BITS + 16);

    // Rec.709 luminance weights in Q16, summing to one
    localparam logic [16:0] LUM_R = 17'd13933;
    localparam logic [16:0] LUM_G = 17'd46871;
    localparam logic [16:0] LUM_B = 17'd4732;

    // pipeline depth: two luminance stages, then the per-channel encoder
    localparam int DIV_STEPS  = 24;
    localparam int SQRT_STEPS = 26;
    localparam int CBRT_STEPS = 21;
    localparam int FRONT_LAT  = 2;
    localparam int CHAN_LAT   = DIV_STEPS + 1 + 2 * SQRT_STEPS + 3;
    localparam int PIPE_LAT   = FRONT_LAT + CHAN_LAT;

endpackage

>>> rtl/rsrgb_chan.sv
// ----------------------------------------------------------------------------
// rsrgb_chan
// One color channel: divide by (1 + L), clamp, sRGB encode to 8 bits.
// ----------------------------------------------------------------------------
module rsrgb_chan import rsrgb_pkg::*; (
    input  logic                    aclk,
    input  logic                    adv,
    input  logic signed [31:0]      chan,
    input  logic [DEN_W-1:0]        den,
    output logic [7:0]              code
);

    localparam logic [24:0] Q24_ONE   = 25'h100_0000;
    localparam logic [24:0] LIN_LIMIT = 25'd52526;
    localparam logic [25:0] RECIP_100 = 26'd42949673;
    localparam logic [16:0] GAIN_Q16  = 17'd69140;
    localparam logic signed [29:0] OFFS_Q24 = 30'sd922747;

    typedef struct packed {
        logic        is_one;
        logic        is_lin;
        logic [26:0] lin_x;
    } enc_ctl_t;

    typedef struct packed {
        logic [27:0] rem;
        logic [25:0] root;
    } sqrt_st_t;

    // one digit of the restoring square root
    function automatic sqrt_st_t sqrt_step(sqrt_st_t s, logic [1:0] pair);
        logic [29:0] r2;
        logic [29:0] trial;
        sqrt_st_t    o;
        r2    = {s.rem, pair};
        trial = {2'b00, s.root, 2'b01};
        if (r2 >= trial) begin
            o.rem  = 28'(r2 - trial);
            o.root = {s.root[24:0], 1'b1};
        end else begin
            o.rem  = 28'(r2);
            o.root = {s.root[24:0], 1'b0};
        end
        return o;
    endfunction

    // ---------------- division ----------------
    logic        pos;
    logic [49:0] num;
    logic        sat;

    assign pos = (chan > 32'sd0);
    assign num = {3'b000, chan[30:0], 16'h0000};
    assign sat = (num >= {1'b0, den});

    logic [49:0]      dv_rem_reg  [DIV_STEPS];
    logic [23:0]      dv_quo_reg  [DIV_STEPS];
    logic [DEN_W-1:0] dv_den_reg  [DIV_STEPS];
    logic [1:0]       dv_flag_reg [DIV_STEPS];  // {one, zero}

    genvar j;
    generate
        for (j = 0; j < DIV_STEPS; j++) begin : g_div
            logic [49:0]      rem_in;
            logic [23:0]      quo_in;
            logic [DEN_W-1:0] den_in;
            logic [1:0]       flag_in;
            logic [49:0]      rem2;
            logic             ge;
            if (j == 0) begin : g_first
                assign rem_in  = num;
                assign quo_in  = '0;
                assign den_in  = den;
                assign flag_in = {pos & sat, ~pos};
            end else begin : g_rest
                assign rem_in  = dv_rem_reg[j-1];
                assign quo_in  = dv_quo_reg[j-1];
                assign den_in  = dv_den_reg[j-1];
                assign flag_in = dv_flag_reg[j-1];
            end
            assign rem2 = {rem_in[48:0], 1'b0};
            assign ge   = (rem2 >= {1'b0, den_in});
            always_ff @(posedge aclk) begin
                if (adv) begin
                    dv_rem_reg[j]  <= ge ? rem2 - {1'b0, den_in} : rem2;
                    dv_quo_reg[j]  <= {quo_in[22:0], ge};
                    dv_den_reg[j]  <= den_in;
                    dv_flag_reg[j] <= flag_in;
                end
            end
        end
    endgenerate

    // ---------------- clamp to Q24 ----------------
    logic [24:0] v_next;
    logic [24:0] v_reg;
    enc_ctl_t    v_ctl_reg;

    always_comb begin
        v_next = {1'b0, dv_quo_reg[DIV_STEPS-1]};
        if (dv_flag_reg[DIV_STEPS-1][0])
            v_next = '0;
        else if (dv_flag_reg[DIV_STEPS-1][1])
            v_next = Q24_ONE;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            v_reg            <= v_next;
            v_ctl_reg.is_one <= v_next[24];
            v_ctl_reg.is_lin <= (v_next <= LIN_LIMIT);
            v_ctl_reg.lin_x  <= 27'({11'd0, v_next[15:0]} * 27'd1292);
        end
    end

    // ---------------- s2 = sqrt(v) ----------------
    logic [51:0] sa_n_reg   [SQRT_STEPS];
    sqrt_st_t    sa_st_reg  [SQRT_STEPS];
    enc_ctl_t    sa_ctl_reg [SQRT_STEPS];

    generate
        for (j = 0; j < SQRT_STEPS; j++) begin : g_sqa
            logic [51:0] n_in;
            sqrt_st_t    st_in;
            enc_ctl_t    ctl_in;
            if (j == 0) begin : g_first
                assign n_in   = {4'h0, v_reg[23:0], 24'h0};
                assign st_in  = '0;
                assign ctl_in = v_ctl_reg;
            end else begin : g_rest
                assign n_in   = sa_n_reg[j-1];
                assign st_in  = sa_st_reg[j-1];
                assign ctl_in = sa_ctl_reg[j-1];
            end
            always_ff @(posedge aclk) begin
                if (adv) begin
                    sa_n_reg[j]   <= {n_in[49:0], 2'b00};
                    sa_st_reg[j]  <= sqrt_step(st_in, n_in[51:50]);
                    sa_ctl_reg[j] <= ctl_in;
                end
            end
        end
    endgenerate

    // ---------------- s4 = sqrt(s2), s6 = cbrt(s2) side by side ----------------
    logic [23:0] s2;
    assign s2 = sa_st_reg[SQRT_STEPS-1].root[23:0];

    logic [51:0] sb_n_reg   [SQRT_STEPS];
    sqrt_st_t    sb_st_reg  [SQRT_STEPS];
    enc_ctl_t    sb_ctl_reg [SQRT_STEPS];
    logic [59:0] cb_n_reg   [SQRT_STEPS];
    logic [20:0] cb_y_reg   [SQRT_STEPS];
    logic [41:0] cb_y2_reg  [SQRT_STEPS];
    logic [62:0] cb_y3_reg  [SQRT_STEPS];

    generate
        for (j = 0; j < SQRT_STEPS; j++) begin : g_sqb
            logic [51:0] n_in;
            sqrt_st_t    st_in;
            enc_ctl_t    ctl_in;
            logic [59:0] cn_in;
            logic [20:0] y_in;
            logic [41:0] y2_in;
            logic [62:0] y3_in;
            if (j == 0) begin : g_first
                assign n_in   = {4'h0, s2, 24'h0};
                assign st_in  = '0;
                assign ctl_in = sa_ctl_reg[SQRT_STEPS-1];
                assign cn_in  = {s2, 36'h0};
                assign y_in   = '0;
                assign y2_in  = '0;
                assign y3_in  = '0;
            end else begin : g_rest
                assign n_in   = sb_n_reg[j-1];
                assign st_in  = sb_st_reg[j-1];
                assign ctl_in = sb_ctl_reg[j-1];
                assign cn_in  = cb_n_reg[j-1];
                assign y_in   = cb_y_reg[j-1];
                assign y2_in  = cb_y2_reg[j-1];
                assign y3_in  = cb_y3_reg[j-1];
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    sb_n_reg[j]   <= {n_in[49:0], 2'b00};
                    sb_st_reg[j]  <= sqrt_step(st_in, n_in[51:50]);
                    sb_ctl_reg[j] <= ctl_in;
                    cb_n_reg[j]   <= cn_in;
                end
            end

            if (j < CBRT_STEPS) begin : g_cbrt
                localparam int K = CBRT_STEPS - 1 - j;
                logic [63:0] t1;
                logic [63:0] t2;
                logic [63:0] cand3;
                logic        fit;
                // (y + 2^K)^3 from y, y^2 and y^3
                assign t1    = {22'd0, y2_in} + {21'd0, y2_in, 1'b0};
                assign t2    = {43'd0, y_in} + {42'd0, y_in, 1'b0};
                assign cand3 = {1'b0, y3_in} + (t1 << K) + (t2 << (2 * K))
                             + (64'd1 << (3 * K));
                assign fit   = (cand3 <= {4'h0, cn_in});
                always_ff @(posedge aclk) begin
                    if (adv) begin
                        if (fit) begin
                            cb_y_reg[j]  <= y_in | (21'd1 << K);
                            cb_y2_reg[j] <= y2_in + ({21'd0, y_in} << (K + 1))
                                          + (42'd1 << (2 * K));
                            cb_y3_reg[j] <= cand3[62:0];
                        end else begin
                            cb_y_reg[j]  <= y_in;
                            cb_y2_reg[j] <= y2_in;
                            cb_y3_reg[j] <= y3_in;
                        end
                    end
                end
            end else begin : g_hold
                always_ff @(posedge aclk) begin
                    if (adv) begin
                        cb_y_reg[j]  <= y_in;
                        cb_y2_reg[j] <= y2_in;
                        cb_y3_reg[j] <= y3_in;
                    end
                end
            end
        end
    endgenerate

    // ---------------- power and linear segment ----------------
    logic [46:0] p_prod_reg;
    logic [52:0] lin_prod_reg;
    enc_ctl_t    p_ctl_reg;
    logic [43:0] pw_prod_reg;
    logic [20:0] lin_y_reg;
    logic        y_one_reg;
    logic        y_lin_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_prod_reg   <= {21'd0, sb_st_reg[SQRT_STEPS-1].root}
                          * {26'd0, cb_y_reg[SQRT_STEPS-1]};
            lin_prod_reg <= {26'd0, sb_ctl_reg[SQRT_STEPS-1].lin_x} * {27'd0, RECIP_100};
            p_ctl_reg    <= sb_ctl_reg[SQRT_STEPS-1];
            pw_prod_reg  <= {17'd0, p_prod_reg[46:20]} * {27'd0, GAIN_Q16};
            lin_y_reg    <= lin_prod_reg[52:32];
            y_one_reg    <= p_ctl_reg.is_one;
            y_lin_reg    <= p_ctl_reg.is_lin;
        end
    end

    // ---------------- round to 8 bits ----------------
    logic signed [29:0] y_val;
    logic [37:0]        y_scaled;
    logic [7:0]         code_next;
    logic [7:0]         code_reg;

    always_comb begin
        if (y_lin_reg)
            y_val = $signed({9'd0, lin_y_reg});
        else
            y_val = $signed({2'b00, pw_prod_reg[43:16]}) - OFFS_Q24;
        y_scaled = 38'({8'd0, y_val[29:0]} * 38'd255) + 38'h80_0000;
        if (y_one_reg)
            code_next = 8'hFF;
        else if (y_val <= 30'sd0)
            code_next = 8'h00;
        else if (y_scaled[37:32] != 6'd0)
            code_next = 8'hFF;
        else
            code_next = y_scaled[31:24];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            code_reg <= code_next;
        end
    end

    assign code = code_reg;

endmodule

>>> rtl/reinhard_srgb_tonemap.sv
// ----------------------------------------------------------------------------
// reinhard_srgb_tonemap
// Reinhard tonemap on Rec.709 luminance followed by sRGB encode to 8 bits.
// ----------------------------------------------------------------------------
//
//   channel   ports             payload                          width
//   input     s_tvalid/tready   red, green, blue  (signed Q15.16) 96
//   output    m_tvalid/tready   red, green, blue  (8-bit sRGB)    24
//
// One pixel enters per clock while no stall holds the pipeline; pixels leave in order.
// Depth is set by the per-channel restoring divider (24 steps) and the two
// chained root units (26 steps each), one digit per stage.
// aresetn clears only the valid bits; payload registers are not reset.
// A stall freezes the whole pipeline: s_tready drops only while a result
// waits at the output and the sink holds m_tready low.
//
module reinhard_srgb_tonemap import rsrgb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,    // red_in[31:0], green_in[63:32], blue_in[95:64]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata     // red_out[7:0], green_out[15:8], blue_out[23:16]
);

    // advance every stage together unless a finished result is held back
    logic adv;
    assign adv      = ~m_tvalid | m_tready;
    assign s_tready = adv;

    // valid bits travel alongside the payload
    logic [PIPE_LAT-1:0] vld_reg;
    logic [PIPE_LAT-1:0] vld_next;

    assign vld_next = {vld_reg[PIPE_LAT-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    assign m_tvalid = vld_reg[PIPE_LAT-1];

    // stage A: weight each channel
    logic signed [31:0] r_a_reg, g_a_reg, b_a_reg;
    logic signed [48:0] pr_reg, pg_reg, pb_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            r_a_reg <= s_tdata[31:0];
            g_a_reg <= s_tdata[63:32];
            b_a_reg <= s_tdata[95:64];
            pr_reg  <= 49'($signed(s_tdata[31:0]))  * 49'($signed({1'b0, LUM_R}));
            pg_reg  <= 49'($signed(s_tdata[63:32])) * 49'($signed({1'b0, LUM_G}));
            pb_reg  <= 49'($signed(s_tdata[95:64])) * 49'($signed({1'b0, LUM_B}));
        end
    end

    // stage B: sum luminance, form 1 + max(L, 0) as the common divisor
    logic signed [50:0] lum;
    logic [DEN_W-1:0]   den_reg;
    logic signed [31:0] r_b_reg, g_b_reg, b_b_reg;

    assign lum = 51'(pr_reg) + 51'(pg_reg) + 51'(pb_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            den_reg <= (lum > 51'sd0) ? DEN_ONE + lum[DEN_W-1:0] : DEN_ONE;
            r_b_reg <= r_a_reg;
            g_b_reg <= g_a_reg;
            b_b_reg <= b_a_reg;
        end
    end

    // three identical encoder lanes share the divisor
    rsrgb_chan u_red (
        .aclk (aclk),
        .adv  (adv),
        .chan (r_b_reg),
        .den  (den_reg),
        .code (m_tdata[7:0])
    );

    rsrgb_chan u_green (
        .aclk (aclk),
        .adv  (adv),
        .chan (g_b_reg),
        .den  (den_reg),
        .code (m_tdata[15:8])
    );

    rsrgb_chan u_blue (
        .aclk (aclk),
        .adv  (adv),
        .chan (b_b_reg),
        .den  (den_reg),
        .code (m_tdata[23:16])
    );

endmodule

>>> rtl/rsrgb_chk.sv
// ----------------------------------------------------------------------------
// rsrgb_chk
// Port-level checks for reinhard_srgb_tonemap, bound to the top level.
// ----------------------------------------------------------------------------
module rsrgb_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // a held result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a held result keeps its value
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // input is refused only while the output is blocked
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input stalled without output backpressure");

    // reset empties the pipeline
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // an offered input is never withdrawn before its transfer
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid)
        else $error("input offer withdrawn before transfer");

endmodule

bind reinhard_srgb_tonemap rsrgb_chk u_rsrgb_chk (.*);

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream test of the Reinhard tonemap / sRGB encoder. Pixels go in through a
// queue-fed driver. A monitor checks every result against a pixel-accurate
// integer model of the tonemap and the sRGB curve.
// ----------------------------------------------------------------------------
module tb;
    import rsrgb_pkg::*;

    typedef struct packed {
        logic signed [31:0] blue;
        logic signed [31:0] green;
        logic signed [31:0] red;
    } pixel_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } code_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        in_taken;

    pixel_t pending_px[$];
    code_t  expected_codes[$];
    int     send_idle_pct;
    int     sink_stall_pct;
    int     hold_cycles;
    int     errors;
    int     pixels_sent;
    int     codes_seen;

    reinhard_srgb_tonemap dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),      // red[31:0], green[63:32], blue[95:64]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)       // red[7:0], green[15:8], blue[23:16]
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // floor square root, 26 result bits
    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned cand;
        root = 0;
        for (int b = 25; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= n) root = cand;
        end
        return root;
    endfunction

    // floor cube root, 21 result bits
    function automatic longint unsigned floor_cbrt(longint unsigned n);
        longint unsigned root;
        longint unsigned cand;
        root = 0;
        for (int b = 20; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand * cand <= n) root = cand;
        end
        return root;
    endfunction

    // channel / (1 + L), clamped to 0..1, as Q24
    function automatic longint unsigned tonemap_q24(longint chan, longint unsigned den);
        longint unsigned num;
        longint unsigned rem;
        longint unsigned quo;
        if (chan <= 0) return 0;
        num = longint'(chan) << 16;
        if (num >= den) return 64'd16777216;
        rem = num;
        quo = 0;
        for (int i = 0; i < 24; i++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        return quo;
    endfunction

    // sRGB transfer of a Q24 linear value, rounded to 8 bits
    function automatic logic [7:0] srgb_code(longint unsigned v);
        longint y;
        longint code;
        longint unsigned s2, s4, s6, p;
        if (v >= 64'd16777216) return 8'd255;
        if (v <= 64'd52526) begin
            y = longint'(v * 1292 / 100);
        end else begin
            s2 = floor_sqrt(v << 24);
            s4 = floor_sqrt(s2 << 24);
            s6 = floor_cbrt(s2 << 36);
            p  = (s4 * s6) >> 20;
            y  = longint'((64'd69140 * p) >> 16) - 922747;
        end
        if (y <= 0) return 8'd0;
        code = (255 * y + (64'sd1 << 23)) >>> 24;
        if (code > 255) code = 255;
        return code[7:0];
    endfunction

    function automatic code_t tonemap_pixel(pixel_t px);
        longint r, g, b, lum;
        longint unsigned den;
        code_t c;
        r   = px.red;
        g   = px.green;
        b   = px.blue;
        lum = 13933 * r + 46871 * g + 4732 * b;
        den = 64'd1 << (FRAC_BITS + 16);
        if (lum > 0) den += lum;
        c.red   = srgb_code(tonemap_q24(r, den));
        c.green = srgb_code(tonemap_q24(g, den));
        c.blue  = srgb_code(tonemap_q24(b, den));
        return c;
    endfunction

    // random channel: mostly around the display range, sometimes any 32 bits
    function automatic logic [31:0] rand_chan();
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return -$urandom_range(0, 32'h0002_0000);
            2:       return $urandom_range(0, 32'h0000_0400);
            default: return $urandom_range(0, 32'h0008_0000);
        endcase
    endfunction

    // driver: drop the head once its transfer is seen, hold an offer until taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (in_taken) begin
                void'(pending_px.pop_front());
                pixels_sent++;
            end
            if (pending_px.size() != 0 &&
                ((s_tvalid && !in_taken) || $urandom_range(0, 99) >= send_idle_pct)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_px[0];
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // predict on the accepted pixel at the rising edge, flag the transfer
    always @(posedge aclk) begin
        in_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready)
            expected_codes.push_back(tonemap_pixel(pixel_t'(s_tdata)));
    end

    // sink: random stalls, or a long hold-off counted here
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // monitor: compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        code_t want;
        code_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            codes_seen++;
            if (expected_codes.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = expected_codes.pop_front();
                if (got.red !== want.red) begin
                    $display("%0t: red expected %0d got %0d", $time, want.red, got.red);
                    errors++;
                end
                if (got.green !== want.green) begin
                    $display("%0t: green expected %0d got %0d", $time, want.green,
                             got.green);
                    errors++;
                end
                if (got.blue !== want.blue) begin
                    $display("%0t: blue expected %0d got %0d", $time, want.blue, got.blue);
                    errors++;
                end
            end
        end
    end

    task automatic add_px(logic [31:0] r, logic [31:0] g, logic [31:0] b);
        pixel_t px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        pending_px.push_back(px);
    endtask

    // wait until the queue is drained and every result is back
    task automatic drain();
        while (pending_px.size() != 0 || s_tvalid || expected_codes.size() != 0)
            @(posedge aclk);
    endtask

    task automatic random_run(int count, int idle, int stall);
        send_idle_pct  = idle;
        sink_stall_pct = stall;
        for (int i = 0; i < count; i++) add_px(rand_chan(), rand_chan(), rand_chan());
        drain();
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        in_taken       = 1'b0;
        hold_cycles    = 0;
        errors         = 0;
        pixels_sent    = 0;
        codes_seen     = 0;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, black, white, negatives, linear knee, saturation
        add_px(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        add_px(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_px(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_px(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        add_px(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        add_px(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        add_px(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000);
        add_px(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000);
        add_px(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
        add_px(32'h0000_00CD, 32'h0000_00CE, 32'h0000_00CC);
        add_px(32'h0000_0100, 32'h0000_0010, 32'h0000_8000);
        add_px(32'h0010_0000, 32'h0000_0000, 32'h0000_0000);
        add_px(32'h0000_0000, 32'h0000_0000, 32'h0010_0000);
        add_px(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        add_px(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        add_px(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
        add_px(32'h0002_0000, 32'hFFFE_0000, 32'h0001_8000);
        drain();

        random_run(250, 0, 0);
        random_run(200, 82, 0);
        random_run(200, 0, 82);
        random_run(200, 33, 33);

        // hold the sink off so the pipe fills and back-pressures the input
        send_idle_pct = 0;
        sink_stall_pct = 0;
        hold_cycles = 300;
        for (int i = 0; i < 200; i++) add_px(rand_chan(), rand_chan(), rand_chan());
        drain();

        repeat (PIPE_LAT + 20) @(posedge aclk);
        $display("tb: %0d pixels sent, %0d results checked across idle/stall phases",
                 pixels_sent, codes_seen);
        $display("tb: covered extremes, negatives, linear segment and output back-pressure");
        if (errors == 0 && expected_codes.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: FAIL");
        $finish;
    end
endmodule
